@@ rtl/flood_dedup_relay_filter_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the flood dedup relay filter
// Each check is clocked on the rising edge and held off while reset is low.
// ----------------------------------------------------------------------------
`ifndef FLOOD_DEDUP_RELAY_FILTER_DEFINES_SVH
`define FLOOD_DEDUP_RELAY_FILTER_DEFINES_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define FDRF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define FDRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/fdrf_pkg.sv @@
// ----------------------------------------------------------------------------
// fdrf_pkg
// Shared types and constants of the flood dedup relay filter.
// ----------------------------------------------------------------------------
package fdrf_pkg;

	// Request codes
	localparam logic [1:0] REQ_RX   = 2'd0;
	localparam logic [1:0] REQ_OWN  = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;

	// Configuration register indexes
	localparam logic CFG_NODE_ID  = 1'b0;
	localparam logic CFG_LIFETIME = 1'b1;

	// Hop field layout and addresses
	localparam logic [7:0]  HOP_TTL_MASK   = 8'hF0;
	localparam logic [7:0]  HOP_FWD_BIT    = 8'h02;
	localparam logic [7:0]  BCAST_ID       = 8'hFF;
	localparam logic [19:0] LIFETIME_RESET = 20'd30000;

	typedef struct packed {
		logic [7:0]  source;
		logic [7:0]  seqn;
		logic [31:0] expiry;
	} entry_t;

	// Sequencer to scan unit
	typedef struct packed {
		logic start;
		logic en;
	} scan_ctl_t;

	// Scan unit to sequencer
	typedef struct packed {
		logic dup;
		logic free_found;
	} scan_sts_t;

endpackage

@@ rtl/flood_dedup_relay_filter.sv @@
// ----------------------------------------------------------------------------
// flood_dedup_relay_filter
// The input header is latched, then checked against the cache through the
// one-entry-per-cycle scan of the cache memory read port; a duplicate
// ends the scan early. A time tick or an unknown request gives no result beat.
// The input stalls for the whole scan and write step, and longer while the result
// beat is held.
// Reset clears all valid bits at once (no clearing pass), time and registers.
// ----------------------------------------------------------------------------
`include "flood_dedup_relay_filter_defines.svh"

module flood_dedup_relay_filter #(
	parameter int CACHE_ENTRIES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [19:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  source_id,
	input  logic [7:0]  sequence_req,
	input  logic [7:0]  dest_id,
	input  logic [7:0]  hop_bits,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_duplicate,
	output logic        deliver_local,
	output logic        do_forward,
	output logic [7:0]  new_hop_bits,
	output logic        evicted
);
	import fdrf_pkg::*;

	localparam int IDX_W = $clog2(CACHE_ENTRIES);
	localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_WRITE
	} state_t;

	state_t      state_q;
	logic [CNT_W-1:0] rd_cnt_q;
	logic [31:0] cur_time_q;
	logic [7:0]  node_id_q;
	logic [19:0] lifetime_q;

	// latched request
	logic [1:0]  req_q;
	logic [7:0]  src_q;
	logic [7:0]  seq_q;
	logic [7:0]  dst_q;
	logic [7:0]  hop_q;

	// output register
	logic        out_valid_q;
	logic        dup_out_q;
	logic        deliver_q;
	logic        fwd_q;
	logic [7:0]  nhop_q;
	logic        evict_q;

	logic             in_accept;
	logic             out_free;
	logic             rd_en;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	entry_t           rd_entry_s1;
	logic             rd_valid_s1;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_entry;
	scan_ctl_t        scan_ctl;
	scan_sts_t        scan_sts;
	logic             hit;
	logic [IDX_W-1:0] free_idx_q;
	logic [IDX_W-1:0] old_idx_q;
	logic             scan_last;

	// result of the decision, computed from the latched header
	logic [3:0]  ttl;
	logic        res_deliver;
	logic        res_fwd;
	logic [7:0]  res_nhop;

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// Issue one read per cycle until every entry has been fetched
	assign rd_en = (state_q == S_SCAN) && (rd_cnt_q < CNT_W'(CACHE_ENTRIES));

	// Compare only while scanning and before a duplicate has been seen
	assign scan_ctl.start = in_accept && ((req_type == REQ_RX) || (req_type == REQ_OWN));
	assign scan_ctl.en    = rd_vld_s1 && (state_q == S_SCAN) && !scan_sts.dup;
	assign scan_last      = rd_idx_s1 == IDX_W'(CACHE_ENTRIES - 1);

	// Store into the first stale slot, else evict the oldest live entry
	assign wr_en            = (state_q == S_WRITE) && out_free && !scan_sts.dup;
	assign wr_addr          = scan_sts.free_found ? free_idx_q : old_idx_q;
	assign wr_entry.source  = src_q;
	assign wr_entry.seqn    = seq_q;
	assign wr_entry.expiry  = cur_time_q + {12'd0, lifetime_q};

	// Delivery and relay decision for a unique received header
	assign ttl         = hop_q[7:4];
	assign res_deliver = (req_q == REQ_RX) && ((dst_q == node_id_q) || (dst_q == BCAST_ID));
	assign res_fwd     = (req_q == REQ_RX) && (dst_q != node_id_q) && (ttl != 4'd0);
	assign res_nhop    = res_fwd ?
		((hop_q & ~HOP_TTL_MASK) | {ttl - 4'd1, 4'd0} | HOP_FWD_BIT) : 8'd0;

	fdrf_entry_store #(
		.CACHE_ENTRIES(CACHE_ENTRIES),
		.IDX_W        (IDX_W)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (rd_en),
		.rd_addr    (rd_cnt_q[IDX_W-1:0]),
		.rd_vld_s1  (rd_vld_s1),
		.rd_idx_s1  (rd_idx_s1),
		.rd_entry_s1(rd_entry_s1),
		.rd_valid_s1(rd_valid_s1),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_entry   (wr_entry)
	);

	fdrf_scan_unit #(
		.CACHE_ENTRIES(CACHE_ENTRIES),
		.IDX_W        (IDX_W)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (scan_ctl),
		.cur_time    (cur_time_q),
		.key_source  (src_q),
		.key_sequence(seq_q),
		.ent         (rd_entry_s1),
		.ent_valid   (rd_valid_s1),
		.ent_idx     (rd_idx_s1),
		.hit         (hit),
		.sts         (scan_sts),
		.free_idx_q  (free_idx_q),
		.old_idx_q   (old_idx_q)
	);

	// Configuration registers; write only while idle (the block does not enforce this)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q  <= 8'd0;
			lifetime_q <= LIFETIME_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NODE_ID:  node_id_q  <= cfg_data[7:0];
				CFG_LIFETIME: lifetime_q <= cfg_data;
				default:      node_id_q  <= node_id_q;
			endcase
		end
	end

	// Sequencer, time base and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_cnt_q    <= '0;
			cur_time_q  <= 32'd0;
			req_q       <= REQ_RX;
			src_q       <= 8'd0;
			seq_q       <= 8'd0;
			dst_q       <= 8'd0;
			hop_q       <= 8'd0;
			out_valid_q <= 1'b0;
			dup_out_q   <= 1'b0;
			deliver_q   <= 1'b0;
			fwd_q       <= 1'b0;
			nhop_q      <= 8'd0;
			evict_q     <= 1'b0;
		end else begin
			// drop the result beat once taken; the write step reloads it itself
			if (out_valid_q && !out_stall && (state_q != S_WRITE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						case (req_type)
							REQ_RX, REQ_OWN: begin
								req_q    <= req_type;
								src_q    <= source_id;
								seq_q    <= sequence_req;
								dst_q    <= dest_id;
								hop_q    <= hop_bits;
								rd_cnt_q <= '0;
								state_q  <= S_SCAN;
							end
							REQ_TICK: cur_time_q <= cur_time_q + 32'd1;
							default:  state_q    <= S_IDLE;
						endcase
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						rd_cnt_q <= rd_cnt_q + CNT_W'(1);
					end
					// advance on a live match or after the last entry
					if (scan_ctl.en && (hit || scan_last)) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					// hold until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						dup_out_q   <= scan_sts.dup;
						deliver_q   <= !scan_sts.dup && res_deliver;
						fwd_q       <= !scan_sts.dup && res_fwd;
						nhop_q      <= scan_sts.dup ? 8'd0 : res_nhop;
						evict_q     <= !scan_sts.dup && !scan_sts.free_found;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign is_duplicate  = dup_out_q;
	assign deliver_local = deliver_q;
	assign do_forward    = fwd_q;
	assign new_hop_bits  = nhop_q;
	assign evicted       = evict_q;

	`FDRF_ASSERT_NOW(a_dup_quiet, clk, arst_n, out_valid && is_duplicate, !deliver_local && !do_forward && !evicted && (new_hop_bits == 8'd0), "duplicate beat carries relay or eviction flags")
	`FDRF_ASSERT_NOW(a_fwd_mark, clk, arst_n, out_valid && do_forward, new_hop_bits[1], "forwarded beat lacks forwarded bit")
	`FDRF_ASSERT_NOW(a_rd_bound, clk, arst_n, state_q == S_SCAN, rd_cnt_q <= CNT_W'(CACHE_ENTRIES), "scan read counter ran past the cache")
	`FDRF_ASSERT_NEXT(a_tick_step, clk, arst_n, in_accept && (req_type == REQ_TICK), cur_time_q == $past(cur_time_q) + 32'd1, "tick did not advance time by one")
	`FDRF_ASSERT_NOW(a_out_src, clk, arst_n, $rose(out_valid), $past(state_q) == S_WRITE, "result beat raised outside the write step")

endmodule

@@ rtl/fdrf_entry_store.sv @@
// ----------------------------------------------------------------------------
// fdrf_entry_store
// Cache entry memory with registered read and flip-flop valid bits.
// ----------------------------------------------------------------------------
module fdrf_entry_store #(
	parameter int CACHE_ENTRIES = 32,
	parameter int IDX_W         = $clog2(CACHE_ENTRIES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [IDX_W-1:0]     rd_addr,
	output logic                 rd_vld_s1,
	output logic [IDX_W-1:0]     rd_idx_s1,
	output fdrf_pkg::entry_t     rd_entry_s1,
	output logic                 rd_valid_s1,
	input  logic                 wr_en,
	input  logic [IDX_W-1:0]     wr_addr,
	input  fdrf_pkg::entry_t     wr_entry
);
	import fdrf_pkg::*;

	entry_t                   mem_q [CACHE_ENTRIES];
	logic [CACHE_ENTRIES-1:0] valid_q;

	// Memory port: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_entry_s1 <= mem_q[rd_addr];
			rd_idx_s1   <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_vld_s1   <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (rd_en) begin
				rd_valid_s1 <= valid_q[rd_addr];
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

endmodule

@@ rtl/fdrf_scan_unit.sv @@
// ----------------------------------------------------------------------------
// fdrf_scan_unit
// Per-entry expiry, key and age compare, reused once per scanned entry.
// ----------------------------------------------------------------------------
module fdrf_scan_unit #(
	parameter int CACHE_ENTRIES = 32,
	parameter int IDX_W         = $clog2(CACHE_ENTRIES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fdrf_pkg::scan_ctl_t  ctl,
	input  logic [31:0]          cur_time,
	input  logic [7:0]           key_source,
	input  logic [7:0]           key_sequence,
	input  fdrf_pkg::entry_t     ent,
	input  logic                 ent_valid,
	input  logic [IDX_W-1:0]     ent_idx,
	output logic                 hit,
	output fdrf_pkg::scan_sts_t  sts,
	output logic [IDX_W-1:0]     free_idx_q,
	output logic [IDX_W-1:0]     old_idx_q
);
	import fdrf_pkg::*;

	logic [31:0] age_diff;
	logic [31:0] old_diff;
	logic [31:0] old_exp_q;
	logic        stale;
	logic        match;
	logic        older;
	logic        dup_q;
	logic        free_found_q;

	// Wrapping signed time: negative difference means "before"
	assign age_diff = cur_time - ent.expiry;
	assign old_diff = ent.expiry - old_exp_q;
	assign stale    = !ent_valid || !age_diff[31];
	assign match    = (ent.source == key_source) && (ent.seqn == key_sequence);
	assign older    = old_diff[31];
	assign hit      = ctl.en && !stale && match;

	assign sts.dup        = dup_q;
	assign sts.free_found = free_found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dup_q        <= 1'b0;
			free_found_q <= 1'b0;
		end else if (ctl.start) begin
			dup_q        <= 1'b0;
			free_found_q <= 1'b0;
		end else if (ctl.en) begin
			if (stale) begin
				free_found_q <= 1'b1;
			end
			if (hit) begin
				dup_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			if (stale && !free_found_q) begin
				free_idx_q <= ent_idx;
			end
			if (ent_idx == '0) begin
				old_exp_q <= ent.expiry;
				old_idx_q <= '0;
			end else if (!stale && !match && older) begin
				old_exp_q <= ent.expiry;
				old_idx_q <= ent_idx;
			end
		end
	end

endmodule
